// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the power button classifier RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked check, disabled while reset is asserted
`define PBPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pbpc assertion failed");

// A signal that, once high, stays high until reset
`define PBPC_ASSERT_STICKY(lbl, clk, rst_n, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (sig) |=> (sig)) \
        else $error("pbpc sticky signal dropped");

`endif

// ----- rtl/pbpc_pkg.sv -----
// Package for the power button classifier: payload and threshold types,
// register indexes and reset values. No dependencies.
package pbpc_pkg;

    localparam int unsigned NOW_BITS       = 32;
    localparam int unsigned THRESH_BITS    = 16;
    localparam int unsigned CFG_INDEX_BITS = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_POWERDOWN = 2'd1,
        CFG_FORCEON   = 2'd2
    } cfg_index_t;

    localparam logic [THRESH_BITS-1:0] DEBOUNCE_RESET  = 16'd50;
    localparam logic [THRESH_BITS-1:0] POWERDOWN_RESET = 16'd2000;
    localparam logic [THRESH_BITS-1:0] FORCEON_RESET   = 16'd5000;

    typedef struct packed {
        logic [THRESH_BITS-1:0] debounce_ms;
        logic [THRESH_BITS-1:0] powerdown_ms;
        logic [THRESH_BITS-1:0] forceon_ms;
    } thresh_t;

    typedef struct packed {
        logic [NOW_BITS-1:0] now_ms;
        logic                button_level;
        logic                ack_press;
        logic                ack_force_on;
    } poll_t;

    typedef struct packed {
        logic press_pending;
        logic powerdown_request;
        logic force_on_request;
        logic held_at_startup;
    } result_t;

endpackage

// ----- rtl/pbpc_poll_if.sv -----
// Poll channel: one button sample with its millisecond time and acks.
// Depends on pbpc_pkg for field widths.
interface pbpc_poll_if;
    logic                          valid;
    logic                          ready;
    logic [pbpc_pkg::NOW_BITS-1:0] now_ms;
    logic                          button_level;
    logic                          ack_press;
    logic                          ack_force_on;

    modport source (output valid, now_ms, button_level, ack_press, ack_force_on,
                    input ready);
    modport sink (input valid, now_ms, button_level, ack_press, ack_force_on,
                  output ready);
endinterface

// ----- rtl/pbpc_result_if.sv -----
// Result channel: the four classifier flags for one poll.
// No package dependencies.
interface pbpc_result_if;
    logic valid;
    logic ready;
    logic press_pending;
    logic powerdown_request;
    logic force_on_request;
    logic held_at_startup;

    modport source (output valid, press_pending, powerdown_request, force_on_request,
                    held_at_startup, input ready);
    modport sink (input valid, press_pending, powerdown_request, force_on_request,
                  held_at_startup, output ready);
endinterface

// ----- rtl/pbpc_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on pbpc_pkg for widths.
interface pbpc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pbpc_pkg::CFG_INDEX_BITS-1:0] index;
    logic [pbpc_pkg::THRESH_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/power_button_press_classifier.sv -----
// Top level of the power button press classifier: poll register, core, result register.
// Depends on pbpc_pkg, the channel interfaces, pbpc_cfg_regs and pbpc_core.
//
//  channel   dir   transfer fields
//  poll      in    now_ms, button_level, ack_press, ack_force_on
//  result    out   press_pending, powerdown_request, force_on_request, held_at_startup
//  cfg       in    index, data (threshold write)
//
// One poll per cycle sustained while the result is taken; a poll is captured in the poll register,
// then its result in the result register, from which it transfers.
// The combinational subtract/compare path between poll and result registers sets the rate.
// rst_n clears the pipeline, classification state and thresholds to their reset values.
// A stalled result holds the pipeline; the poll register still fills behind it.
module power_button_press_classifier #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    pbpc_poll_if.sink    poll,
    pbpc_result_if.source result,
    pbpc_cfg_if.sink     cfg
);
    import pbpc_pkg::*;

    poll_t   poll_item;
    poll_t   in_item_reg;
    logic    in_valid_reg, in_valid_next;
    result_t core_res;
    result_t out_item_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    poll_xfer;
    thresh_t thresh;

    assign poll_item.now_ms       = poll.now_ms;
    assign poll_item.button_level = poll.button_level;
    assign poll_item.ack_press    = poll.ack_press;
    assign poll_item.ack_force_on = poll.ack_force_on;

    // Pipeline flow control
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready = !in_valid_reg || advance;
    assign poll_xfer  = poll.valid && poll.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (poll_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (poll_xfer)
        begin
            in_item_reg <= poll_item;
        end
        if (advance)
        begin
            out_item_reg <= core_res;
        end
    end

    pbpc_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .thresh (thresh)
    );

    pbpc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .poll   (in_item_reg),
        .thresh (thresh),
        .res    (core_res)
    );

    assign result.valid             = out_valid_reg;
    assign result.press_pending     = out_item_reg.press_pending;
    assign result.powerdown_request = out_item_reg.powerdown_request;
    assign result.force_on_request  = out_item_reg.force_on_request;
    assign result.held_at_startup   = out_item_reg.held_at_startup;

endmodule

// ----- rtl/pbpc_cfg_regs.sv -----
// Threshold registers written over the configuration channel.
// Depends on pbpc_pkg and pbpc_cfg_if.
module pbpc_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    pbpc_cfg_if.sink          cfg,
    output pbpc_pkg::thresh_t thresh
);
    import pbpc_pkg::*;

    thresh_t thresh_reg;
    thresh_t thresh_next;

    // Writes are always taken
    assign cfg.ready = 1'b1;

    // Decode the register index; unknown indexes are dropped
    always_comb
    begin
        thresh_next = thresh_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_DEBOUNCE:  thresh_next.debounce_ms  = cfg.data;
                CFG_POWERDOWN: thresh_next.powerdown_ms = cfg.data;
                CFG_FORCEON:   thresh_next.forceon_ms   = cfg.data;
                default:       thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.debounce_ms  <= DEBOUNCE_RESET;
            thresh_reg.powerdown_ms <= POWERDOWN_RESET;
            thresh_reg.forceon_ms   <= FORCEON_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

    assign thresh = thresh_reg;

endmodule

// ----- rtl/pbpc_core.sv -----
// Press classification state and next-state logic for one poll per step.
// Depends on pbpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pbpc_core #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  pbpc_pkg::poll_t   poll,
    input  pbpc_pkg::thresh_t thresh,
    output pbpc_pkg::result_t res
);
    import pbpc_pkg::*;

    // Zero-extend or truncate to the time width
    logic [TIME_BITS+NOW_BITS-1:0]    now_wide;
    logic [TIME_BITS+THRESH_BITS-1:0] deb_wide;
    logic [TIME_BITS+THRESH_BITS-1:0] pd_wide;
    logic [TIME_BITS+THRESH_BITS-1:0] fo_wide;
    logic [TIME_BITS-1:0]             now_t;
    logic [TIME_BITS-1:0]             deb_t;
    logic [TIME_BITS-1:0]             pd_t;
    logic [TIME_BITS-1:0]             fo_t;

    logic                 started_reg,   started_next;
    logic                 prev_reg,      prev_next;
    logic                 startup_reg,   startup_next;
    logic [TIME_BITS-1:0] start_reg,     start_next;
    logic [TIME_BITS-1:0] held_reg,      held_next;
    logic                 short_reg,     short_next;
    logic                 pd_reg,        pd_next;
    logic                 fo_reg,        fo_next;
    logic                 short_upd;
    logic                 fo_upd;

    assign now_wide = {{TIME_BITS{1'b0}}, poll.now_ms};
    assign deb_wide = {{TIME_BITS{1'b0}}, thresh.debounce_ms};
    assign pd_wide  = {{TIME_BITS{1'b0}}, thresh.powerdown_ms};
    assign fo_wide  = {{TIME_BITS{1'b0}}, thresh.forceon_ms};
    assign now_t    = now_wide[TIME_BITS-1:0];
    assign deb_t    = deb_wide[TIME_BITS-1:0];
    assign pd_t     = pd_wide[TIME_BITS-1:0];
    assign fo_t     = fo_wide[TIME_BITS-1:0];

    // Edge handling, hold timing and threshold checks
    always_comb
    begin
        started_next = started_reg;
        prev_next    = prev_reg;
        startup_next = startup_reg;
        start_next   = start_reg;
        held_next    = held_reg;
        short_upd    = short_reg;
        pd_next      = pd_reg;
        fo_upd       = fo_reg;
        if (!started_reg)
        begin
            // first poll only captures the level
            prev_next    = poll.button_level;
            startup_next = poll.button_level;
            started_next = 1'b1;
        end
        else
        begin
            if (prev_reg != poll.button_level)
            begin
                if (prev_reg)
                begin
                    // release
                    if ((held_reg > deb_t) && !startup_reg)
                    begin
                        short_upd = 1'b1;
                    end
                    startup_next = 1'b0;
                end
                else
                begin
                    // press: stamp the time
                    start_next = now_t;
                end
                prev_next = poll.button_level;
            end
            if (poll.button_level)
            begin
                held_next = now_t - start_next;
                if ((held_next >= pd_t) && !startup_next)
                begin
                    pd_next   = 1'b1;
                    held_next = '0;
                end
                if ((held_next >= fo_t) && startup_next)
                begin
                    fo_upd    = 1'b1;
                    held_next = '0;
                end
            end
        end
        // acks apply after the result is formed
        short_next = short_upd & ~poll.ack_press;
        fo_next    = fo_upd & ~poll.ack_force_on;
    end

    assign res.press_pending     = short_upd;
    assign res.powerdown_request = pd_next;
    assign res.force_on_request  = fo_upd;
    assign res.held_at_startup   = startup_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            prev_reg    <= 1'b0;
            startup_reg <= 1'b0;
            start_reg   <= '0;
            held_reg    <= '0;
            short_reg   <= 1'b0;
            pd_reg      <= 1'b0;
            fo_reg      <= 1'b0;
        end
        else if (step)
        begin
            started_reg <= started_next;
            prev_reg    <= prev_next;
            startup_reg <= startup_next;
            start_reg   <= start_next;
            held_reg    <= held_next;
            short_reg   <= short_next;
            pd_reg      <= pd_next;
            fo_reg      <= fo_next;
        end
    end

    // Checks on the classification state
    `PBPC_ASSERT_STICKY(a_pd_sticky, clk, rst_n, pd_reg)
    `PBPC_ASSERT_STICKY(a_started_sticky, clk, rst_n, started_reg)
    `PBPC_ASSERT(a_fo_only_startup, clk, rst_n, $rose(fo_reg) |-> startup_reg)
    `PBPC_ASSERT(a_short_not_startup, clk, rst_n, $rose(short_reg) |-> !startup_reg)
    `PBPC_ASSERT(a_idle_holds, clk, rst_n, !step |=> $stable(held_reg) && $stable(start_reg))

endmodule
